[sv/dsim_pkg.sv]
// Package for the detector symmetry index map.
// Holds register codes, datapath widths and the structs passed between the cells.
`default_nettype none
package dsim_pkg;

   localparam int IDX_W  = 16;
   localparam int DIV_W  = 19;
   localparam int REM_W  = 20;
   localparam int LEN_W  = 14;
   localparam int TOT_W  = 26;
   localparam int SUM_W  = 27;
   localparam int CSR_W  = 7;

   localparam logic [SUM_W-1:0] MAX_CRYSTALS = SUM_W'(65536);

   typedef enum logic [1:0] {
      CSR_BLOCK_SIZE = 2'd0,
      CSR_NUM_BLOCKS = 2'd1,
      CSR_NUM_LAYERS = 2'd2,
      CSR_NUM_RINGS  = 2'd3
   } dsim_csr_type;

   // Derived geometry, recomputed every cycle from the configuration registers.
   typedef struct packed {
      logic [LEN_W-1:0] layer_len;
      logic [DIV_W-1:0] ring_len;
      logic [TOT_W-1:0] total;
      logic [LEN_W-1:0] off_x;
      logic [LEN_W-1:0] off_y;
      logic [6:0]       num_rings;
   } dsim_geom_type;

   // One transaction as it moves down the divider chain.
   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] idx;
      logic [2:0]       mode;
      logic [IDX_W-1:0] hi_q;
      logic [REM_W-1:0] rem;
      logic [IDX_W-1:0] num;
      logic [IDX_W-1:0] quot;
   } dsim_cell_type;

endpackage
`default_nettype wire

[sv/dsim_div_cell.sv]
// One restoring-division cell: retires one quotient bit per transaction.
// Depends on dsim_pkg.
`default_nettype none
module dsim_div_cell import dsim_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [DIV_W-1:0] divisor,
   input  wire dsim_cell_type    din,
   output dsim_cell_type         dout
);
   dsim_cell_type    cell_ff, cell_in;
   logic [REM_W-1:0] trial;
   logic             take;

   always_comb begin
      trial   = {din.rem[REM_W-2:0], din.num[IDX_W-1]};
      take    = trial >= {1'b0, divisor};
      cell_in = din;
      cell_in.rem  = take ? trial - {1'b0, divisor} : trial;
      cell_in.num  = {din.num[IDX_W-2:0], 1'b0};
      cell_in.quot = {din.quot[IDX_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign dout = cell_ff;
endmodule
`default_nettype wire

[sv/dsim_mirror.sv]
// Back end: applies the x, y and z mirrors and rebuilds the linear index.
// Three register stages. Depends on dsim_pkg.
`default_nettype none
module dsim_mirror import dsim_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dsim_geom_type geom,
   input  wire dsim_cell_type din,
   output logic               rsp_strobe,
   output logic [IDX_W-1:0]   rsp_mapped_index,
   output logic               rsp_out_of_range
);
   logic             vld1_ff, vld2_ff, vld3_ff;
   logic [IDX_W-1:0] idx1_ff, idx2_ff;
   logic [2:0]       mode1_ff;
   logic [LEN_W-1:0] v1_ff, v2_in, v2_ff, v1_in;
   logic [4:0]       l1_ff;
   logic [6:0]       r1_ff, r1_in;
   logic [DIV_W-1:0] lp2_ff;
   logic [TOT_W-1:0] rp2_ff;
   logic [LEN_W:0]   tx, ty;
   logic [SUM_W-1:0] sum;
   logic             ok;
   logic [IDX_W-1:0] map_ff;
   logic             oor_ff;

   always_comb begin
      // Position within the layer lies below layer_len, so one subtract folds the sum.
      tx = {1'b0, geom.layer_len} - {1'b0, din.rem[LEN_W-1:0]} + {1'b0, geom.off_x};
      if (tx >= {1'b0, geom.layer_len}) begin
         tx = tx - {1'b0, geom.layer_len};
      end
      v1_in = din.mode[0] ? tx[LEN_W-1:0] : din.rem[LEN_W-1:0];
      r1_in = din.mode[2] ? geom.num_rings - 7'd1 - din.hi_q[6:0] : din.hi_q[6:0];

      ty = {1'b0, geom.layer_len} - {1'b0, v1_ff} + {1'b0, geom.off_y};
      if (ty >= {1'b0, geom.layer_len}) begin
         ty = ty - {1'b0, geom.layer_len};
      end
      v2_in = mode1_ff[1] ? ty[LEN_W-1:0] : v1_ff;

      sum = SUM_W'(v2_ff) + SUM_W'(lp2_ff) + SUM_W'(rp2_ff);
      ok  = (geom.total != '0) && (TOT_W'(idx2_ff) < geom.total) && (sum < MAX_CRYSTALS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= din.vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= din.idx;
      mode1_ff <= din.mode;
      v1_ff    <= v1_in;
      l1_ff    <= din.quot[4:0];
      r1_ff    <= r1_in;
      idx2_ff  <= idx1_ff;
      v2_ff    <= v2_in;
      lp2_ff   <= DIV_W'(l1_ff * geom.layer_len);
      rp2_ff   <= TOT_W'(r1_ff * geom.ring_len);
      map_ff   <= ok ? sum[IDX_W-1:0] : idx2_ff;
      oor_ff   <= !ok;
   end

   assign rsp_strobe       = vld3_ff;
   assign rsp_mapped_index = map_ff;
   assign rsp_out_of_range = oor_ff;
endmodule
`default_nettype wire

[sv/detector_symmetry_index_map.sv]
// Detector symmetry index map: configuration registers, input stages and the two
// divider chains of dsim_div_cell, followed by dsim_mirror. Depends on dsim_pkg.
//
// Usage: a transaction is taken at each rising edge with start high; busy is
// always low, so one crystal index with its mode can enter every cycle.
// The index is split into ring, layer and position by two chains of sixteen
// division cells (one quotient bit per cell), then mirrored and rebuilt.
// Each result appears on the rsp_ ports for one cycle with rsp_strobe high,
// in order, one per transaction, after passing the two input stages, both
// cell chains and the mirror stages. Throughput is one transaction per cycle.
// The receiver cannot stall, so nothing is ever held back.
// Configuration is written through csr_we/csr_index/csr_wdata while no
// transaction is in flight; it takes effect for a transaction started in
// the next cycle.
// Synchronous reset empties the pipeline and loads the default geometry
// (8 crystals per block, 4 blocks, 1 layer, 1 ring).
`default_nettype none
module detector_symmetry_index_map import dsim_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [IDX_W-1:0] req_crystal_index,
   input  wire logic [2:0]       req_mode,
   output logic                  rsp_strobe,
   output logic [IDX_W-1:0]      rsp_mapped_index,
   output logic                  rsp_out_of_range,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);
   logic [6:0]    block_size_ff, num_blocks_ff, num_rings_ff;
   logic [4:0]    num_layers_ff;
   dsim_geom_type geom_ff;
   dsim_cell_type s0_ff, s1_ff, s0_in;
   dsim_cell_type layer_head;
   dsim_cell_type c1 [0:IDX_W];
   dsim_cell_type c2 [0:IDX_W];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= 7'd8;
         num_blocks_ff <= 7'd4;
         num_layers_ff <= 5'd1;
         num_rings_ff  <= 7'd1;
      end else if (csr_we) begin
         case (dsim_csr_type'(csr_index))
            CSR_BLOCK_SIZE: block_size_ff <= csr_wdata;
            CSR_NUM_BLOCKS: num_blocks_ff <= csr_wdata;
            CSR_NUM_LAYERS: num_layers_ff <= csr_wdata[4:0];
            CSR_NUM_RINGS:  num_rings_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Products are chained through registers; the two input stages cover the lag.
   always_ff @(posedge clock) begin
      geom_ff.layer_len <= LEN_W'(block_size_ff * num_blocks_ff);
      geom_ff.ring_len  <= DIV_W'(geom_ff.layer_len * num_layers_ff);
      geom_ff.total     <= TOT_W'(geom_ff.ring_len * num_rings_ff);
      geom_ff.off_x     <= LEN_W'(block_size_ff) - LEN_W'(1);
      geom_ff.off_y     <= LEN_W'(block_size_ff * ({1'b0, num_blocks_ff[6:1]} + 7'd1))
                           - LEN_W'(1);
      geom_ff.num_rings <= num_rings_ff;
   end

   always_comb begin
      s0_in      = '0;
      s0_in.vld  = start;
      s0_in.idx  = req_crystal_index;
      s0_in.mode = req_mode;
      s0_in.num  = req_crystal_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff <= '0;
         s1_ff <= '0;
      end else begin
         s0_ff <= s0_in;
         s1_ff <= s0_ff;
      end
   end

   assign c1[0] = s1_ff;

   always_comb begin
      layer_head      = c1[IDX_W];
      layer_head.hi_q = c1[IDX_W].quot;
      layer_head.num  = c1[IDX_W].rem[IDX_W-1:0];
      layer_head.rem  = '0;
      layer_head.quot = '0;
   end

   assign c2[0] = layer_head;

   for (genvar i = 0; i < IDX_W; i++) begin : g_ring
      dsim_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .divisor (geom_ff.ring_len),
         .din     (c1[i]),
         .dout    (c1[i+1])
      );
   end

   for (genvar i = 0; i < IDX_W; i++) begin : g_layer
      dsim_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .divisor (DIV_W'(geom_ff.layer_len)),
         .din     (c2[i]),
         .dout    (c2[i+1])
      );
   end

   dsim_mirror u_mirror (
      .clock            (clock),
      .reset            (reset),
      .geom             (geom_ff),
      .din              (c2[IDX_W]),
      .rsp_strobe       (rsp_strobe),
      .rsp_mapped_index (rsp_mapped_index),
      .rsp_out_of_range (rsp_out_of_range)
   );
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for detector_symmetry_index_map.
// Drives crystal indexes and mirror modes, predicts each mapped index and
// compares it in order; depends on dsim_pkg and the block's RTL.
`default_nettype none
module tb;
   import dsim_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [IDX_W-1:0] req_crystal_index = '0;
   logic [2:0]       req_mode = '0;
   logic             rsp_strobe;
   logic [IDX_W-1:0] rsp_mapped_index;
   logic             rsp_out_of_range;
   logic             csr_we = 1'b0;
   logic [1:0]       csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   localparam int LATENCY = 37;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [15:0] index;
      logic        oor;
   } mapped_type;

   typedef struct {
      logic [15:0] index;
      logic [2:0]  mode;
      bit          typed;
      mapped_type  want;
   } vector_type;

   logic [6:0] geo_block_size, geo_num_blocks, geo_num_rings;
   logic [4:0] geo_num_layers;
   mapped_type expected_maps[$];
   int         error_count = 0;
   int         idle_cycles = 0;

   detector_symmetry_index_map dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic mapped_type mirror_index(logic [15:0] index, logic [2:0] mode);
      longint unsigned layer_len, ring_len, total, r, rem, l, v, res;
      mapped_type m;
      layer_len = geo_block_size * geo_num_blocks;
      ring_len  = layer_len * geo_num_layers;
      total     = ring_len * geo_num_rings;
      m.index = index;
      m.oor   = 1'b1;
      if (total == 0 || index >= total) return m;
      r   = index / ring_len;
      rem = index % ring_len;
      l   = rem / layer_len;
      v   = rem % layer_len;
      if (mode[0]) v = (layer_len - v + geo_block_size - 1) % layer_len;
      if (mode[1])
         v = (layer_len - v + geo_block_size * (geo_num_blocks / 2 + 1) - 1) % layer_len;
      // Ring index is unsigned; the z image always stays inside the ring range.
      if (mode[2]) r = geo_num_rings - 1 - r;
      res = v + l * layer_len + r * ring_len;
      if (res >= 65536) return m;
      m.index = res[15:0];
      m.oor   = 1'b0;
      return m;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   // Results are sampled at the edge that ends their strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_maps.size() == 0) begin
            report_mismatch("result with no transaction pending");
         end else begin
            mapped_type w;
            w = expected_maps.pop_front();
            if (rsp_mapped_index !== w.index)
               report_mismatch($sformatf("mapped_index got %0d, expected %0d",
                                         rsp_mapped_index, w.index));
            if (rsp_out_of_range !== w.oor)
               report_mismatch($sformatf("out_of_range got %0d, expected %0d",
                                         rsp_out_of_range, w.oor));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_register(dsim_csr_type which, logic [6:0] value);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (which)
         CSR_BLOCK_SIZE: geo_block_size = value;
         CSR_NUM_BLOCKS: geo_num_blocks = value;
         CSR_NUM_LAYERS: geo_num_layers = value[4:0];
         CSR_NUM_RINGS:  geo_num_rings  = value;
         default: ;
      endcase
   endtask

   task automatic set_geometry(logic [6:0] bs, logic [6:0] nb, logic [4:0] nl,
                               logic [6:0] nr);
      write_register(CSR_BLOCK_SIZE, bs);
      write_register(CSR_NUM_BLOCKS, nb);
      write_register(CSR_NUM_LAYERS, {2'b00, nl});
      write_register(CSR_NUM_RINGS, nr);
   endtask

   task automatic drain();
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // With gaps on, idles a random number of cycles first; start stays high
   // after the transaction is taken so the next one can follow at once.
   task automatic send_crystal(logic [15:0] index, logic [2:0] mode, bit typed,
                               mapped_type want, bit gaps);
      mapped_type p;
      p = mirror_index(index, mode);
      if (typed && p !== want)
         report_mismatch($sformatf("predictor disagrees with table for index %0d",
                                   index));
      if (gaps) begin
         while ($urandom_range(99) < 36) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start             <= 1'b1;
      req_crystal_index <= index;
      req_mode          <= mode;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_maps.push_back(typed ? want : p);
   endtask

   vector_type directed[] = '{
      '{16'd0,     3'd0, 1'b1, '{16'd0, 1'b0}},
      '{16'd0,     3'd1, 1'b1, '{16'd7, 1'b0}},
      '{16'd31,    3'd0, 1'b1, '{16'd31, 1'b0}},
      '{16'd32,    3'd0, 1'b1, '{16'd32, 1'b1}},
      '{16'hFFFF,  3'd7, 1'b1, '{16'hFFFF, 1'b1}},
      '{16'd5,     3'd2, 1'b0, '{16'd0, 1'b0}},
      '{16'd5,     3'd3, 1'b0, '{16'd0, 1'b0}},
      '{16'd5,     3'd4, 1'b1, '{16'd5, 1'b0}},
      '{16'd9,     3'd5, 1'b0, '{16'd0, 1'b0}},
      '{16'd17,    3'd6, 1'b0, '{16'd0, 1'b0}},
      '{16'd30,    3'd7, 1'b0, '{16'd0, 1'b0}},
      '{16'hAAAA,  3'd1, 1'b1, '{16'hAAAA, 1'b1}},
      '{16'h5555,  3'd2, 1'b1, '{16'h5555, 1'b1}}
   };

   typedef logic [6:0] geo_type[4];
   geo_type geometries[] = '{
      '{7'd64, 7'd64, 7'd16, 7'd64},  // image can pass 16 bits: flagged
      '{7'd1, 7'd1, 7'd1, 7'd1},
      '{7'd0, 7'd4, 7'd1, 7'd1},      // zero register: all flagged
      '{7'd127, 7'd127, 7'd31, 7'd127},
      '{7'd3, 7'd5, 7'd2, 7'd7},
      '{7'd8, 7'd6, 7'd4, 7'd16},
      '{7'd16, 7'd32, 7'd2, 7'd64},
      '{7'd2, 7'd64, 7'd16, 7'd8}
   };

   initial begin
      int n;
      logic [15:0] idx;
      longint unsigned total;
      geo_block_size = 7'd8;
      geo_num_blocks = 7'd4;
      geo_num_layers = 5'd1;
      geo_num_rings  = 7'd1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_crystal(directed[i].index, directed[i].mode, directed[i].typed,
                      directed[i].want, 1'b0);
      start <= 1'b0;
      drain();

      foreach (geometries[g]) begin
         set_geometry(geometries[g][0], geometries[g][1], geometries[g][2][4:0],
                      geometries[g][3]);
         total = geo_block_size * geo_num_blocks * geo_num_layers * geo_num_rings;
         n = (g == 0) ? 150 : 255;
         for (int k = 0; k < n; k++) begin
            // Mostly in-range indexes, some anywhere in the 16-bit space.
            if (total != 0 && $urandom_range(99) < 80)
               idx = 16'($urandom_range(32'(total > 65536 ? 65535 : total - 1)));
            else
               idx = 16'($urandom());
            send_crystal(idx, 3'($urandom_range(7)), 1'b0, '0, !(k >= 60 && k < 120));
         end
         start <= 1'b0;
         drain();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_maps.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
sv/dsim_pkg.sv
sv/dsim_div_cell.sv
sv/dsim_mirror.sv
sv/detector_symmetry_index_map.sv
tb/tb.sv
